@@ sv/bbars_pkg.sv @@
package bbars_pkg;

  localparam int unsigned MAX_RUN_LENGTH_DEF    = 65535;
  localparam int unsigned MAX_RUNS_PER_ITEM_DEF = 64;
  localparam int unsigned BLOCK_ADDR_BITS_DEF   = 48;

  localparam int unsigned FIELD_W   = 48;
  localparam int unsigned IN_DATA_W = 104;
  localparam int unsigned OUT_DATA_W = 208;
  localparam logic [4:0]  MAX_GROUP_SHIFT = 5'd16;

  typedef enum logic [1:0] {
    CMD_BUMP   = 2'd0,
    CMD_RUN    = 2'd1,
    CMD_BITMAP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_FIRST_FREE = 2'd0,
    REG_GROUP_SHIFT = 2'd1,
    REG_NUM_BLOCKS = 2'd2,
    REG_BIG_ENDIAN = 2'd3
  } reg_idx_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_BUMP = 7'b0000010,
    ST_RUN_A = 7'b0000100,
    ST_RUN_B = 7'b0001000,
    ST_RUN_C = 7'b0010000,
    ST_BM_A = 7'b0100000,
    ST_BM_B = 7'b1000000
  } state_t;

  // bit b is used when b is below the cursor count or at/above the volume end
  function automatic logic [31:0] bitmap_word(input logic [5:0] n_below,
                                              input logic [5:0] n_avail,
                                              input logic       swap);
    logic [31:0] w;
    for (int b = 0; b < 32; b++) begin
      w[b] = (6'(b) < n_below) || (6'(b) >= n_avail);
    end
    if (swap) begin
      w = {w[7:0], w[15:8], w[23:16], w[31:24]};
    end
    return w;
  endfunction

endpackage

@@ sv/bbars_addsub.sv @@
module bbars_addsub #(
  parameter int unsigned W = 49
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] y
);

  logic [W-1:0] b_inv;

  assign b_inv = sub ? ~b : b;
  assign y     = a + b_inv + W'(sub);

endmodule

@@ sv/bump_block_allocator_run_splitter_core.sv @@
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata: count, run_limit, word_index; tuser: cmd
// m_axis    out  m_axis_tvalid/tready      tdata: result fields; tlast: last
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One shared add/subtract unit serves every command under a small sequencer.
// Bump allocate uses ST_BUMP, bitmap read ST_BM_A then ST_BM_B, and a run stream
// loops RUN_A, RUN_B, RUN_C per run (used, remaining, cursor each go through it).
// s_axis_tready is high only when the sequencer is idle; cfg is always ready.
// A result waits in the output register; the sequencer stalls on a full one.
// Reset is synchronous and clears the cursor to zero.
module bump_block_allocator_run_splitter_core #(
  parameter int unsigned MAX_RUN_LENGTH    = bbars_pkg::MAX_RUN_LENGTH_DEF,
  parameter int unsigned MAX_RUNS_PER_ITEM = bbars_pkg::MAX_RUNS_PER_ITEM_DEF,
  parameter int unsigned BLOCK_ADDR_BITS   = bbars_pkg::BLOCK_ADDR_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // count[47:0], run_limit[54:48], word_index[97:55], zero pad[103:98]
  input  logic [103:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // start_block[47:0], group_number[95:48], start_in_group[111:96],
  // run_length[127:112], consumed[175:128], bitmap_word[207:176]
  output logic [207:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  localparam int unsigned CW = BLOCK_ADDR_BITS;
  localparam int unsigned WW = (CW > 48) ? CW : 48;
  localparam int unsigned UW = WW + 1;

  bbars_pkg::state_t state;

  logic [4:0]    group_shift;
  logic [47:0]   num_blocks;
  logic          big_endian;
  logic [CW-1:0] cursor;

  // remaining blocks for a run stream, count for bump, base block for bitmap
  logic [47:0] operand;
  logic [47:0] used;
  logic [15:0] chunk;
  logic [6:0]  n_runs;
  logic [6:0]  lim;
  logic [5:0]  n_below;

  logic          out_valid;
  logic [47:0]   out_start;
  logic [47:0]   out_group;
  logic [15:0]   out_sig;
  logic [15:0]   out_len;
  logic [47:0]   out_used;
  logic [31:0]   out_word;
  logic          out_last;

  logic [UW-1:0] ua, ub, uy;
  logic          usub;

  logic [4:0]  sh;
  logic [16:0] gsize, mask17, off17, to_end, c1;
  logic [15:0] chunk_c;
  logic        rem_small;
  logic [47:0] cur_group;
  logic        slot;
  logic        emit;
  logic        run_last;
  logic [5:0]  sat;

  logic [1:0]  in_cmd;
  logic [47:0] in_count;
  logic [6:0]  in_limit, lim_eff;
  logic [42:0] in_widx;

  assign in_cmd   = s_axis_tuser;
  assign in_count = s_axis_tdata[47:0];
  assign in_limit = s_axis_tdata[54:48];
  assign in_widx  = s_axis_tdata[97:55];
  assign lim_eff  = (in_limit > 7'(MAX_RUNS_PER_ITEM)) ? 7'(MAX_RUNS_PER_ITEM) : in_limit;

  assign s_axis_tready = (state == bbars_pkg::ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign slot          = !out_valid || m_axis_tready;
  // a result word is loaded into the output register this cycle
  assign emit          = slot && ((state == bbars_pkg::ST_BUMP) ||
                                  (state == bbars_pkg::ST_RUN_C) ||
                                  (state == bbars_pkg::ST_BM_B));

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {out_word, out_used, out_len, out_sig, out_group, out_start};

  // group geometry of the cursor
  assign sh        = (group_shift > bbars_pkg::MAX_GROUP_SHIFT) ?
                     bbars_pkg::MAX_GROUP_SHIFT : group_shift;
  assign gsize     = 17'(1) << sh;
  assign mask17    = gsize - 17'd1;
  assign off17     = {1'b0, cursor[15:0]} & mask17;
  assign to_end    = gsize - off17;
  assign cur_group = 48'(cursor >> sh);
  assign rem_small = (operand[47:17] == '0) && (operand[16:0] < to_end);
  assign c1        = rem_small ? operand[16:0] : to_end;
  assign chunk_c   = (c1 > 17'(MAX_RUN_LENGTH)) ? 16'(MAX_RUN_LENGTH) : c1[15:0];
  assign run_last  = (operand == '0) || (7'(n_runs + 7'd1) == lim);

  // distance through the unit, clamped to one word
  assign sat = uy[WW] ? 6'd0 :
               ((uy[WW-1:6] != '0) || (uy[5:0] > 6'd32)) ? 6'd32 : uy[5:0];

  always_comb begin
    ua   = '0;
    ub   = '0;
    usub = 1'b0;
    unique case (state)
      bbars_pkg::ST_BUMP: begin
        ua = UW'(cursor);
        ub = UW'(operand);
      end
      bbars_pkg::ST_RUN_A: begin
        ua = UW'(used);
        ub = UW'(chunk_c);
      end
      bbars_pkg::ST_RUN_B: begin
        ua   = UW'(operand);
        ub   = UW'(chunk);
        usub = 1'b1;
      end
      bbars_pkg::ST_RUN_C: begin
        ua = UW'(cursor);
        ub = UW'(chunk);
      end
      bbars_pkg::ST_BM_A: begin
        ua   = UW'(cursor);
        ub   = UW'(operand);
        usub = 1'b1;
      end
      bbars_pkg::ST_BM_B: begin
        ua   = UW'(num_blocks);
        ub   = UW'(operand);
        usub = 1'b1;
      end
      default: begin
        ua   = '0;
        ub   = '0;
        usub = 1'b0;
      end
    endcase
  end

  bbars_addsub #(
    .W(UW)
  ) u_addsub (
    .a  (ua),
    .b  (ub),
    .sub(usub),
    .y  (uy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= bbars_pkg::ST_IDLE;
      out_valid        <= 1'b0;
      group_shift      <= bbars_pkg::MAX_GROUP_SHIFT;
      num_blocks       <= '0;
      big_endian       <= 1'b0;
      cursor           <= '0;
    end else begin
      if (out_valid && m_axis_tready && !emit) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (bbars_pkg::reg_idx_t'(cfg_index))
          bbars_pkg::REG_FIRST_FREE:  cursor      <= CW'(cfg_data);
          bbars_pkg::REG_GROUP_SHIFT: group_shift <= cfg_data[4:0];
          bbars_pkg::REG_NUM_BLOCKS:  num_blocks  <= cfg_data;
          bbars_pkg::REG_BIG_ENDIAN:  big_endian  <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        bbars_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            unique case (bbars_pkg::cmd_t'(in_cmd))
              bbars_pkg::CMD_BUMP: begin
                operand <= in_count;
                state   <= bbars_pkg::ST_BUMP;
              end
              bbars_pkg::CMD_RUN: begin
                operand <= in_count;
                used    <= '0;
                n_runs  <= '0;
                lim     <= lim_eff;
                if (in_count != '0 && in_limit != '0) begin
                  state <= bbars_pkg::ST_RUN_A;
                end
              end
              bbars_pkg::CMD_BITMAP: begin
                operand <= {in_widx, 5'd0};
                state   <= bbars_pkg::ST_BM_A;
              end
              default: ;
            endcase
          end
        end
        bbars_pkg::ST_BUMP: begin
          if (slot) begin
            out_valid <= 1'b1;
            out_start <= 48'(cursor);
            out_group <= cur_group;
            out_sig   <= off17[15:0];
            out_len   <= '0;
            out_used  <= operand;
            out_word  <= '0;
            out_last  <= 1'b1;
            cursor    <= uy[CW-1:0];
            state     <= bbars_pkg::ST_IDLE;
          end
        end
        bbars_pkg::ST_RUN_A: begin
          chunk <= chunk_c;
          used  <= uy[47:0];
          state <= bbars_pkg::ST_RUN_B;
        end
        bbars_pkg::ST_RUN_B: begin
          operand <= uy[47:0];
          state   <= bbars_pkg::ST_RUN_C;
        end
        bbars_pkg::ST_RUN_C: begin
          // emit the run and advance the cursor past it
          if (slot) begin
            out_valid <= 1'b1;
            out_start <= 48'(cursor);
            out_group <= cur_group;
            out_sig   <= off17[15:0];
            out_len   <= chunk;
            out_used  <= used;
            out_word  <= '0;
            out_last  <= run_last;
            cursor    <= uy[CW-1:0];
            n_runs    <= 7'(n_runs + 7'd1);
            state     <= run_last ? bbars_pkg::ST_IDLE : bbars_pkg::ST_RUN_A;
          end
        end
        bbars_pkg::ST_BM_A: begin
          n_below <= sat;
          state   <= bbars_pkg::ST_BM_B;
        end
        bbars_pkg::ST_BM_B: begin
          if (slot) begin
            out_valid <= 1'b1;
            out_start <= operand;
            out_group <= '0;
            out_sig   <= '0;
            out_len   <= '0;
            out_used  <= '0;
            out_word  <= bbars_pkg::bitmap_word(n_below, sat, big_endian);
            out_last  <= 1'b1;
            state     <= bbars_pkg::ST_IDLE;
          end
        end
        default: state <= bbars_pkg::ST_IDLE;
      endcase
    end
  end

  a_run_under_limit: assert property (@(posedge clk) disable iff (rst)
    (state == bbars_pkg::ST_RUN_A) |-> (n_runs < lim))
    else $error("run stream past its run limit");

  a_run_has_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == bbars_pkg::ST_RUN_A) |-> (operand != '0))
    else $error("run started with no blocks left");

  a_run_len_legal: assert property (@(posedge clk) disable iff (rst)
    (state == bbars_pkg::ST_RUN_C && slot) |=>
      (m_axis_tvalid && out_len != '0 && 32'(out_len) <= 32'(MAX_RUN_LENGTH)))
    else $error("emitted run length out of range");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == bbars_pkg::ST_RUN_C && slot && run_last) |=> (state == bbars_pkg::ST_IDLE))
    else $error("sequencer busy after final run");

endmodule
